// ===== hw/rtl/psc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants shared by the payload sequence checker modules.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int OFFSET_W = 23;
  localparam int SEQ_W    = 64;

  // Largest payload length that can ever be valid.
  localparam logic [OFFSET_W-1:0] MAX_PAYLOAD   = 23'd4194304;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX    = 23'h7FFFFF;
  localparam logic [OFFSET_W-1:0] PAYLOAD_RESET = 23'd1024;

  localparam int HEADER_BYTES = 16;
  localparam int RUN_TARGET   = 10;

  localparam logic [7:0] SEQ_FACTOR    = 8'd131;
  localparam logic [7:0] OFFSET_FACTOR = 8'd17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Outcome of one message, handed from the front end to the statistics.
  typedef struct packed {
    logic             ok;
    logic [SEQ_W-1:0] seq;
  } verdict_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== hw/rtl/psc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_front
// Takes message bytes, gathers the header, checks the pattern and produces
// one verdict per message on its last byte.
// ----------------------------------------------------------------------------
module psc_front
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                path_ok,
  input  logic [SEQ_W-1:0]    expected_seq,
  input  queue_status_t       q_status,
  output logic                push,
  output verdict_t            verdict
);

  logic [OFFSET_W-1:0] payload_length;
  logic [OFFSET_W-1:0] byte_offset;
  logic [SEQ_W-1:0]    header_sequence;
  logic [SEQ_W-1:0]    header_length;
  logic                pattern_good;

  logic [OFFSET_W-1:0] byte_offset_next;
  logic [SEQ_W-1:0]    header_sequence_next;
  logic [SEQ_W-1:0]    header_length_next;
  logic                pattern_good_next;

  logic                accept;
  logic                saturated;
  logic [OFFSET_W:0]   count;
  logic [SEQ_W-1:0]    byte_shifted;
  logic [7:0]          seq_term;
  logic [7:0]          off_term;
  logic [7:0]          expected_b;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign saturated    = (byte_offset == OFFSET_MAX);
  assign count        = {1'b0, byte_offset} + {{OFFSET_W{1'b0}}, 1'b1};
  assign byte_shifted = {{(SEQ_W-8){1'b0}}, data_byte} << {byte_offset[2:0], 3'b000};

  // Only the low byte of the pattern formula matters, so 8-bit arithmetic does.
  assign seq_term   = header_sequence[7:0] * SEQ_FACTOR;
  assign off_term   = byte_offset[7:0] * OFFSET_FACTOR;
  assign expected_b = seq_term + off_term + byte_offset[15:8];

  always_comb begin
    header_sequence_next = header_sequence;
    header_length_next   = header_length;
    pattern_good_next    = pattern_good;
    if (byte_offset < OFFSET_W'(8)) begin
      header_sequence_next = header_sequence | byte_shifted;
    end else if (byte_offset < OFFSET_W'(HEADER_BYTES)) begin
      header_length_next = header_length | byte_shifted;
    end else if (data_byte != expected_b) begin
      pattern_good_next = 1'b0;
    end
    byte_offset_next = saturated ? byte_offset : count[OFFSET_W-1:0];
  end

  assign push        = accept && last_byte;
  assign verdict.seq = header_sequence_next;
  assign verdict.ok  = path_ok && !saturated
                    && (count >= (OFFSET_W+1)'(HEADER_BYTES))
                    && (payload_length <= MAX_PAYLOAD)
                    && (count == {1'b0, payload_length})
                    && (header_sequence_next != '0)
                    && (header_length_next == {{(SEQ_W-OFFSET_W-1){1'b0}}, count})
                    && ((expected_seq == '0) || (header_sequence_next == expected_seq))
                    && pattern_good_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      payload_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      header_sequence <= '0;
      header_length   <= '0;
      pattern_good    <= 1'b1;
    end else if (accept) begin
      if (last_byte) begin
        byte_offset     <= '0;
        header_sequence <= '0;
        header_length   <= '0;
        pattern_good    <= 1'b1;
      end else begin
        byte_offset     <= byte_offset_next;
        header_sequence <= header_sequence_next;
        header_length   <= header_length_next;
        pattern_good    <= pattern_good_next;
      end
    end
  end

endmodule

// ===== hw/rtl/psc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_queue
// Short first-in first-out queue of message verdicts.
// ----------------------------------------------------------------------------
module psc_queue
  import psc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  verdict_t      push_data,
  input  logic          pop,
  output verdict_t      pop_data,
  output queue_status_t status
);

  verdict_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == QCOUNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCOUNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/psc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_back
// Sequence analysis and statistics counters, in two stages. The first stage
// compares each sequence with the last valid one, the second updates the
// counters, which also form the output register.
// ----------------------------------------------------------------------------
module psc_back
  import psc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  queue_status_t    q_status,
  input  verdict_t         q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             message_ok,
  output logic             first_valid_event,
  output logic             contiguous_ten_event,
  output logic [SEQ_W-1:0] valid_total,
  output logic [SEQ_W-1:0] invalid_total,
  output logic [SEQ_W-1:0] gap_total,
  output logic [SEQ_W-1:0] order_error_total,
  output logic [SEQ_W-1:0] first_sequence,
  output logic [SEQ_W-1:0] last_sequence,
  output logic [SEQ_W-1:0] run_length
);

  typedef struct packed {
    logic             ok;
    logic             first;
    logic             extend_run;
    logic             order_err;
    logic [SEQ_W-1:0] gap_inc;
    logic [SEQ_W-1:0] seq;
  } analysis_t;

  // Stage A state: whether any valid message has been seen, and its sequence.
  logic             any_valid;
  logic [SEQ_W-1:0] prev_seq;
  logic             a_valid;
  analysis_t        a_rec;
  analysis_t        a_rec_next;

  logic             a_advance;
  logic [SEQ_W-1:0] prev_plus_one;
  logic             is_next;
  logic             is_greater;
  logic             ten_hit;

  assign a_advance = a_valid && (!out_valid || !out_stall);
  assign pop       = !q_status.empty && (!a_valid || a_advance);

  assign prev_plus_one = prev_seq + SEQ_W'(1);
  assign is_next       = (q_data.seq == prev_plus_one);
  assign is_greater    = (q_data.seq > prev_seq);

  always_comb begin
    a_rec_next.ok         = q_data.ok;
    a_rec_next.seq        = q_data.seq;
    a_rec_next.first      = !any_valid;
    a_rec_next.extend_run = !any_valid || is_next;
    a_rec_next.order_err  = any_valid && !is_greater;
    // seq - prev - 1 is seq plus the complement of prev.
    if (any_valid && is_greater && !is_next) begin
      a_rec_next.gap_inc = q_data.seq + ~prev_seq;
    end else begin
      a_rec_next.gap_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_rec <= a_rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      any_valid <= 1'b0;
      prev_seq  <= '0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
        if (q_data.ok) begin
          any_valid <= 1'b1;
          prev_seq  <= q_data.seq;
        end
      end else if (a_advance) begin
        a_valid <= 1'b0;
      end
    end
  end

  // Both counters reach ten together only if this item extends a run of nine.
  assign ten_hit = a_rec.ok && a_rec.extend_run
                && (run_length == SEQ_W'(RUN_TARGET - 1))
                && (valid_total == SEQ_W'(RUN_TARGET - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid            <= 1'b0;
      message_ok           <= 1'b0;
      first_valid_event    <= 1'b0;
      contiguous_ten_event <= 1'b0;
      valid_total          <= '0;
      invalid_total        <= '0;
      gap_total            <= '0;
      order_error_total    <= '0;
      first_sequence       <= '0;
      last_sequence        <= '0;
      run_length           <= '0;
    end else if (a_advance) begin
      out_valid            <= 1'b1;
      message_ok           <= a_rec.ok;
      first_valid_event    <= a_rec.ok && a_rec.first;
      contiguous_ten_event <= ten_hit;
      if (a_rec.ok) begin
        valid_total       <= valid_total + SEQ_W'(1);
        gap_total         <= gap_total + a_rec.gap_inc;
        order_error_total <= order_error_total + SEQ_W'(a_rec.order_err);
        last_sequence     <= a_rec.seq;
        if (a_rec.first) begin
          first_sequence <= a_rec.seq;
        end
        if (a_rec.extend_run) begin
          run_length <= run_length + SEQ_W'(1);
        end else begin
          run_length <= SEQ_W'(1);
        end
      end else begin
        invalid_total <= invalid_total + SEQ_W'(1);
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_first_is_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_valid_event |-> message_ok && valid_total == SEQ_W'(1))
    else $error("first valid event with a valid count other than one");

  a_ten_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && contiguous_ten_event |->
      run_length == SEQ_W'(RUN_TARGET) && valid_total == SEQ_W'(RUN_TARGET))
    else $error("ten-message event without ten consecutive valid messages");

  a_invalid_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && !message_ok |-> !first_valid_event && !contiguous_ten_event)
    else $error("event flagged on an invalid message");

  a_valid_needs_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_ok |-> last_sequence != '0 && run_length != '0)
    else $error("valid message left a zero sequence or an empty run");

endmodule

// ===== hw/rtl/payload_sequence_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// payload_sequence_checker
// Checks test messages byte by byte and keeps sequence statistics.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle while in_stall is low,
// without pause between messages. Each message yields one result, which
// passes through the verdict queue and stage A into the output register.
// Verdicts wait in a four-entry queue ahead of the statistics stages;
// in_stall is raised only while that queue is full, which happens when
// results are held back at the output.
// payload_length may be written only while no message is in progress.
module payload_sequence_checker
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                path_ok,
  input  logic [SEQ_W-1:0]    expected_seq,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                message_ok,
  output logic                first_valid_event,
  output logic                contiguous_ten_event,
  output logic [SEQ_W-1:0]    valid_total,
  output logic [SEQ_W-1:0]    invalid_total,
  output logic [SEQ_W-1:0]    gap_total,
  output logic [SEQ_W-1:0]    order_error_total,
  output logic [SEQ_W-1:0]    first_sequence,
  output logic [SEQ_W-1:0]    last_sequence,
  output logic [SEQ_W-1:0]    run_length
);

  queue_status_t q_status;
  verdict_t      push_data;
  verdict_t      pop_data;
  logic          push;
  logic          pop;

  psc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .path_ok      (path_ok),
    .expected_seq (expected_seq),
    .q_status     (q_status),
    .push         (push),
    .verdict      (push_data)
  );

  psc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  psc_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_status             (q_status),
    .q_data               (pop_data),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .message_ok           (message_ok),
    .first_valid_event    (first_valid_event),
    .contiguous_ten_event (contiguous_ten_event),
    .valid_total          (valid_total),
    .invalid_total        (invalid_total),
    .gap_total            (gap_total),
    .order_error_total    (order_error_total),
    .first_sequence       (first_sequence),
    .last_sequence        (last_sequence),
    .run_length           (run_length)
  );

endmodule
